@@ src/line_substring_matcher_assert.svh @@
// Assertion macros used by the matcher's top-level RTL file.
// Each macro takes a label, an antecedent and a consequent, and samples on
// the rising edge of clock with the synchronous reset disabling the check.
`ifndef LINE_SUBSTRING_MATCHER_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line matcher check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LSM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line matcher check failed in the following cycle");

`endif

@@ src/lsm_pkg.sv @@
package lsm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   // The configuration registers hold this many pattern bytes.
   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_BITS = 8 * PATTERN_BYTES;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int LENGTH_W = 16;
   localparam int RAW_LEN_W = 5;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LEN  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_MODE    = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IGNORE_CASE  = 8'd4;

   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [RAW_LEN_W-1:0]    pattern_length;
      logic                    word_mode;
      logic                    ignore_case;
   } cfg_type;

   typedef struct packed {
      logic                line_matched;
      logic [LENGTH_W-1:0] line_length;
   } line_result_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ignore_case);
      logic [7:0] r;
      r = c;
      if (ignore_case && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

@@ src/lsm_interfaces.sv @@
interface lsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface lsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          line_matched;
   logic [lsm_pkg::LENGTH_W-1:0]  line_length;

   modport source (output valid, output line_matched, output line_length, input ready);
   modport sink (input valid, input line_matched, input line_length, output ready);
endinterface

interface lsm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lsm_pkg::CSR_INDEX_W-1:0] index;
   logic [lsm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/lsm_csr.sv @@
module lsm_csr (
   input  logic            clock,
   input  logic            reset,
   lsm_csr_if.sink         csr_if,
   output lsm_pkg::cfg_type cfg
);

   lsm_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            lsm_pkg::REG_PATTERN_LOW: begin
               cfg_in.pattern[lsm_pkg::CSR_DATA_W-1:0] = csr_if.data;
            end
            lsm_pkg::REG_PATTERN_HIGH: begin
               cfg_in.pattern[lsm_pkg::PATTERN_BITS-1:lsm_pkg::CSR_DATA_W] = csr_if.data;
            end
            lsm_pkg::REG_PATTERN_LEN: begin
               cfg_in.pattern_length = csr_if.data[lsm_pkg::RAW_LEN_W-1:0];
            end
            lsm_pkg::REG_WORD_MODE: begin
               cfg_in.word_mode = csr_if.data[0];
            end
            lsm_pkg::REG_IGNORE_CASE: begin
               cfg_in.ignore_case = csr_if.data[0];
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern        <= '0;
         cfg_ff.pattern_length <= lsm_pkg::RAW_LEN_W'(1);
         cfg_ff.word_mode      <= 1'b0;
         cfg_ff.ignore_case    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/lsm_match.sv @@
module lsm_match #(
   parameter int MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lsm_pkg::cfg_type         cfg,
   input  logic                     advance,
   input  logic [7:0]               text_byte,
   output lsm_pkg::line_result_type result
);

   localparam int WINDOW = MAX_PATTERN + 1;
   localparam int LEN_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]                  window_ff [WINDOW];
   logic [7:0]                  window_in [WINDOW];
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        found_ff, found_in;
   logic [lsm_pkg::LENGTH_W-1:0] length_ff, length_in;

   logic [7:0]       pat_bytes [MAX_PATTERN];
   logic [7:0]       raw_len8;
   logic [7:0]       act_len8;
   logic [LEN_W-1:0] act_len;
   logic [CNT_W-1:0] act_len_cnt;
   logic [MAX_PATTERN-1:0] pos_ok;
   logic             is_nl;
   logic             bytes_equal;
   logic             left_bad;
   logic             right_bad;
   logic             candidate;

   assign is_nl = (text_byte == lsm_pkg::NEWLINE_BYTE);

   // Pattern bytes past the configured sixteen read as zero.
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (j < lsm_pkg::PATTERN_BYTES) begin
            pat_bytes[j] = cfg.pattern[8*j +: 8];
         end else begin
            pat_bytes[j] = 8'h00;
         end
      end
   end

   // Length zero acts as one, and lengths above MAX_PATTERN act as MAX_PATTERN.
   assign raw_len8 = {{(8 - lsm_pkg::RAW_LEN_W){1'b0}}, cfg.pattern_length};
   always_comb begin
      if (raw_len8 == 8'd0) begin
         act_len8 = 8'd1;
      end else if (raw_len8 > 8'(MAX_PATTERN)) begin
         act_len8 = 8'(MAX_PATTERN);
      end else begin
         act_len8 = raw_len8;
      end
   end
   assign act_len = act_len8[LEN_W-1:0];
   assign act_len_cnt = CNT_W'(act_len);

   // Window slot i holds the byte that must equal pattern byte act_len-1-i.
   always_comb begin
      logic [7:0] rev_idx;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         rev_idx = act_len8 - 8'd1 - 8'(i);
         if (8'(i) >= act_len8) begin
            pos_ok[i] = 1'b1;
         end else begin
            pos_ok[i] = (lsm_pkg::fold_byte(window_ff[i], cfg.ignore_case) ==
                         lsm_pkg::fold_byte(pat_bytes[rev_idx[IDX_W-1:0]], cfg.ignore_case));
         end
      end
   end

   assign bytes_equal = &pos_ok;
   assign right_bad = !is_nl && lsm_pkg::is_alnum(text_byte);
   assign left_bad = (count_ff > act_len_cnt) && lsm_pkg::is_alnum(window_ff[act_len]);
   assign candidate = (count_ff >= act_len_cnt) && bytes_equal &&
                      !(cfg.word_mode && (right_bad || left_bad));

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      length_in = length_ff;
      if (advance) begin
         if (is_nl) begin
            count_in  = '0;
            found_in  = 1'b0;
            length_in = '0;
         end else begin
            window_in[0] = text_byte;
            for (int i = 1; i < WINDOW; i++) begin
               window_in[i] = window_ff[i-1];
            end
            if (count_ff < CNT_W'(WINDOW)) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (length_ff != lsm_pkg::LENGTH_MAX) begin
               length_in = length_ff + lsm_pkg::LENGTH_W'(1);
            end
            found_in = found_ff | candidate;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= 8'h00;
         end
         count_ff  <= '0;
         found_ff  <= 1'b0;
         length_ff <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         length_ff <= length_in;
      end
   end

   assign result.line_matched = found_ff | candidate;
   assign result.line_length  = length_ff;

endmodule

@@ src/line_substring_matcher.sv @@
// Fixed-string line matcher. Text enters on req_if one byte per transfer;
// a byte of 10 ends a line. For every finished line one transfer leaves on
// rsp_if with line_matched (the pattern occurs in the line, as a word in word
// mode) and line_length (bytes before the newline, saturating at 65535). Bytes
// after the last newline produce nothing until their newline arrives.
// The pattern, its length, word mode and case folding are written through
// csr_if, which always accepts, and must only change while the block is idle.
// A byte is captured in an input register and then consumed by the window
// compare; a newline's line result goes into the result register and leaves
// on rsp_if from there. The block sustains one byte per cycle, except while a
// newline waits behind an untaken result; the window compare and line state update set that pace.
// When rsp_if stalls, ordinary bytes keep flowing into the window; only a
// newline waits in the input register while the previous result is still
// held, and req_if.ready drops behind it.
// Reset is synchronous: it clears the configuration to pattern length one,
// word mode and case folding off, and empties the window, the line state
// and both pipeline registers.
module line_substring_matcher #(
   parameter int MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lsm_req_if.sink   req_if,
   lsm_rsp_if.source rsp_if,
   lsm_csr_if.sink   csr_if
);

   `include "line_substring_matcher_assert.svh"

   lsm_pkg::cfg_type         cfg;
   lsm_pkg::line_result_type line_result;

   // Input register: one text byte waiting for the compare stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Result register: one finished line waiting for the receiver.
   logic                         out_valid_ff, out_valid_in;
   logic                         out_matched_ff, out_matched_in;
   logic [lsm_pkg::LENGTH_W-1:0] out_length_ff, out_length_in;

   logic in_is_nl;
   logic advance;
   logic req_take;

   lsm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   lsm_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .text_byte (in_byte_ff),
      .result    (line_result)
   );

   assign in_is_nl = (in_byte_ff == lsm_pkg::NEWLINE_BYTE);

   // A plain byte always moves on; a newline needs room in the result register.
   assign advance = in_valid_ff && (!in_is_nl || !out_valid_ff || rsp_if.ready);

   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.text_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_matched_in = out_matched_ff;
      out_length_in  = out_length_ff;
      if (advance && in_is_nl) begin
         out_valid_in   = 1'b1;
         out_matched_in = line_result.line_matched;
         out_length_in  = line_result.line_length;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      out_matched_ff <= out_matched_in;
      out_length_ff  <= out_length_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.line_matched = out_matched_ff;
   assign rsp_if.line_length  = out_length_ff;

   // A newline held behind an untaken result must block new input.
   `LSM_ASSERT_SAME(a_nl_blocks_input,
      in_valid_ff && in_is_nl && out_valid_ff && !rsp_if.ready, !req_if.ready)

   // A byte that cannot advance stays in the input register unchanged.
   `LSM_ASSERT_NEXT(a_input_holds,
      in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

   // A consumed newline always yields a result carrying the line length.
   `LSM_ASSERT_NEXT(a_nl_gives_result,
      advance && in_is_nl,
      out_valid_ff && (out_length_ff == $past(line_result.line_length)))

   // A result only appears after a newline was consumed.
   `LSM_ASSERT_SAME(a_result_from_nl,
      $rose(out_valid_ff), $past(advance && in_is_nl))

endmodule
